// ----- design/smtb_pkg.sv -----
// Package for the sparse morph target blender: sizes, request codes, payload types,
// and the rounding and saturation helpers.
// No dependencies.
`default_nettype none
package smtb_pkg;
    localparam int Vertices        = 1024;
    localparam int Morphs          = 16;
    localparam int EntriesPerMorph = 256;
    localparam int VW   = $clog2(Vertices);
    localparam int MW   = $clog2(Morphs);
    localparam int EW   = $clog2(EntriesPerMorph);
    localparam int CW   = EW + 1;
    localparam int SW   = MW + EW;
    localparam int CRDW = 20;
    localparam int WTW  = 16;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ENTRY = 2'd1,
        REQ_WEIGHT = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef logic signed [CRDW-1:0] t_crd;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  morph_id;
        logic [9:0]  vertex_index;
        t_crd        coord_x;
        t_crd        coord_y;
        t_crd        coord_z;
        logic signed [WTW-1:0] weight;
        logic        start_of_target;
        logic        last_weight;
    } t_in;

    typedef struct packed {
        t_crd out_x;
        t_crd out_y;
        t_crd out_z;
        logic overflow_seen;
    } t_out;

    // Read request from the back end into the queue of results
    typedef struct packed {
        logic          vld;
        logic [VW-1:0] vix;
        logic          oob;
    } t_rd;

    // product rounded from Q14, ties away from zero
    function automatic logic signed [21:0] round_q14(input logic signed [35:0] p);
        logic [35:0] a;
        logic [35:0] r;
        begin
            a = p[35] ? 36'(-p) : 36'(p);
            r = (a + 36'd8192) >> 14;
            round_q14 = p[35] ? -$signed(r[21:0]) : $signed(r[21:0]);
        end
    endfunction

    function automatic t_crd sat20(input logic signed [22:0] v);
        begin
            if (v > 23'sd524287) sat20 = 20'sh7FFFF;
            else if (v < -23'sd524288) sat20 = 20'sh80000;
            else sat20 = t_crd'(v);
        end
    endfunction
endpackage
`default_nettype wire

// ----- design/smtb_front.sv -----
// Front end: accepts transactions, stores entries and weights, keeps counts and the
// overflow flag, and forwards loads, weights and reads to the command queue. Uses smtb_pkg.
`default_nettype none
module smtb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire smtb_pkg::t_in i_item,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output smtb_pkg::t_in      o_q_item,
    // entry store read port for the back end
    input  wire logic [smtb_pkg::SW-1:0] i_e_addr,
    output logic [3*smtb_pkg::CRDW+smtb_pkg::VW-1:0] o_e_data,
    input  wire logic [smtb_pkg::MW-1:0] i_m_sel,
    output logic [smtb_pkg::CW-1:0]      o_m_cnt,
    output logic signed [smtb_pkg::WTW-1:0] o_m_wt,
    input  wire logic                    i_wt_clr,
    input  wire logic                    i_busy
);
    import smtb_pkg::*;

    logic [3*CRDW+VW-1:0] r_ent [Morphs*EntriesPerMorph];
    logic [CW-1:0]  r_cnt [Morphs];
    logic signed [WTW-1:0] r_wt [Morphs];
    logic r_ovf;
    logic r_hold;
    logic acc;
    logic [CW-1:0] cnt0;
    logic mok;

    // entries and weights are taken in only while the back end is idle; blends hold the front
    // from the last weight until the weight table is cleared
    assign o_full   = i_q_full || i_busy || r_hold;
    assign acc      = i_push && !o_full;
    assign mok      = 32'(i_item.morph_id) < Morphs;
    assign cnt0     = i_item.start_of_target ? '0 : r_cnt[i_item.morph_id[MW-1:0]];
    assign o_q_push = acc && (i_item.req_type != REQ_ENTRY);
    assign o_m_cnt  = r_cnt[i_m_sel];
    assign o_m_wt   = r_wt[i_m_sel];

    // reads carry the overflow flag as seen at acceptance in the unused start field
    always_comb begin
        o_q_item = i_item;
        if (i_item.req_type == REQ_READ) o_q_item.start_of_target = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        o_e_data <= r_ent[i_e_addr];
        if (acc && i_item.req_type == REQ_ENTRY && mok &&
            32'(i_item.vertex_index) < Vertices && 32'(cnt0) < EntriesPerMorph)
            r_ent[{i_item.morph_id[MW-1:0], cnt0[EW-1:0]}] <=
                {i_item.vertex_index[VW-1:0], i_item.coord_x, i_item.coord_y,
                 i_item.coord_z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf  <= 1'b0;
            r_hold <= 1'b0;
            for (int m = 0; m < Morphs; m++) begin
                r_cnt[m] <= '0;
                r_wt[m]  <= '0;
            end
        end else begin
            if (i_wt_clr) begin
                r_hold <= 1'b0;
                for (int m = 0; m < Morphs; m++) r_wt[m] <= '0;
            end
            if (acc && i_item.req_type == REQ_WEIGHT && i_item.last_weight)
                r_hold <= 1'b1;
            if (acc && mok) begin
                if (i_item.req_type == REQ_ENTRY) begin
                    if (32'(i_item.vertex_index) < Vertices) begin
                        if (32'(cnt0) < EntriesPerMorph)
                            r_cnt[i_item.morph_id[MW-1:0]] <= cnt0 + 1'b1;
                        else begin
                            r_cnt[i_item.morph_id[MW-1:0]] <= cnt0;
                            r_ovf <= 1'b1;
                        end
                    end else
                        r_cnt[i_item.morph_id[MW-1:0]] <= cnt0;
                end
                if (i_item.req_type == REQ_WEIGHT)
                    r_wt[i_item.morph_id[MW-1:0]] <= i_item.weight;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/smtb_cmdq.sv -----
// Short command queue between front and back end.
// Uses smtb_pkg.
`default_nettype none
module smtb_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire smtb_pkg::t_in i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output smtb_pkg::t_in      o_item
);
    import smtb_pkg::*;

    t_in r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_n;

    assign o_full  = r_n == 3'd4;
    assign o_empty = r_n == 3'd0;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_q[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_n <= r_n + 3'(i_push && !o_full) - 3'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

// ----- design/smtb_back.sv -----
// Back end: base and blended vertex memories, the blend sequencer (clear pass at reset,
// copy pass, then the entry terms one at a time) and the result queue. Uses smtb_pkg.
`default_nettype none
module smtb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire smtb_pkg::t_in i_item,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_wt_clr,
    output logic [smtb_pkg::SW-1:0] o_e_addr,
    input  wire logic [3*smtb_pkg::CRDW+smtb_pkg::VW-1:0] i_e_data,
    output logic [smtb_pkg::MW-1:0] o_m_sel,
    input  wire logic [smtb_pkg::CW-1:0]    i_m_cnt,
    input  wire logic signed [smtb_pkg::WTW-1:0] i_m_wt,
    output logic               o_empty,
    input  wire logic          i_pop,
    output smtb_pkg::t_out     o_res
);
    import smtb_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_RUN, S_COPY, S_COPYW, S_MSEL, S_EREQ, S_EWAIT, S_MUL, S_BRD, S_ADD, S_DONE
    } t_st;

    logic [3*CRDW-1:0] r_base  [Vertices];
    logic [3*CRDW-1:0] r_blend [Vertices];

    t_st r_st;
    logic [VW:0] r_vc;
    logic [VW-1:0] r_cv;
    logic [MW:0] r_m;
    logic [CW-1:0] r_e;
    logic [3*CRDW-1:0] r_base_rd, r_blend_rd;
    logic [VW-1:0] r_ev;
    logic signed [35:0] r_p [3];
    logic signed [WTW-1:0] r_w;
    // result queue
    t_out r_rq [2];
    logic r_rw, r_rr;
    logic [1:0] r_rn;
    logic r_rd_pend, r_rd_oob, r_rd_ovf;
    logic can_read;
    t_crd sum [3];

    assign can_read = r_rn + 2'(r_rd_pend) < 2'd2;
    assign o_pop    = (r_st == S_RUN) && !i_empty &&
                      (i_item.req_type != REQ_READ || can_read);
    assign o_busy   = r_st != S_RUN;
    assign o_wt_clr = r_st == S_DONE;
    assign o_m_sel  = r_m[MW-1:0];
    assign o_e_addr = {r_m[MW-1:0], r_e[EW-1:0]};
    assign o_empty  = r_rn == 2'd0;
    assign o_res    = r_rq[r_rr];

    always_comb begin
        for (int c = 0; c < 3; c++)
            sum[c] = sat20(23'($signed(r_blend_rd[(2-c)*CRDW +: CRDW])) +
                           23'(round_q14(r_p[c])));
    end

    always_ff @(posedge i_clk) begin
        r_base_rd  <= r_base[(r_st == S_COPY) ? r_vc[VW-1:0] : r_cv];
        r_blend_rd <= r_blend[(r_st == S_BRD || r_st == S_MUL) ? r_ev :
                              (r_st == S_RUN) ? i_item.vertex_index[VW-1:0] : r_cv];
        if (r_st == S_CLR) begin
            r_base[r_vc[VW-1:0]]  <= '0;
            r_blend[r_vc[VW-1:0]] <= '0;
        end else if (r_st == S_RUN && o_pop && i_item.req_type == REQ_LOAD &&
                     32'(i_item.vertex_index) < Vertices)
            r_base[i_item.vertex_index[VW-1:0]] <=
                {i_item.coord_x, i_item.coord_y, i_item.coord_z};
        if (r_st == S_COPYW) r_blend[r_cv] <= r_base_rd;
        else if (r_st == S_ADD) r_blend[r_ev] <= {sum[0], sum[1], sum[2]};
        if (r_st == S_EWAIT) begin
            r_ev <= i_e_data[3*CRDW +: VW];
            for (int c = 0; c < 3; c++)
                r_p[c] <= 36'($signed(i_e_data[(2-c)*CRDW +: CRDW])) * 36'(r_w);
        end
        if (r_rd_pend)
            r_rq[r_rw] <= r_rd_oob ? t_out'({60'd0, r_rd_ovf})
                                   : t_out'({r_blend_rd, r_rd_ovf});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_vc <= '0;
            r_cv <= '0;
            r_m  <= '0;
            r_e  <= '0;
            r_w  <= '0;
            r_rw <= 1'b0;
            r_rr <= 1'b0;
            r_rn <= '0;
            r_rd_pend <= 1'b0;
            r_rd_oob  <= 1'b0;
            r_rd_ovf  <= 1'b0;
        end else begin
            r_rd_pend <= 1'b0;
            if (r_rd_pend) r_rw <= ~r_rw;
            if (i_pop && !o_empty) r_rr <= ~r_rr;
            r_rn <= r_rn + 2'(r_rd_pend) - 2'(i_pop && !o_empty);
            case (r_st)
                S_CLR: begin
                    r_vc <= r_vc + 1'b1;
                    if (32'(r_vc) == Vertices - 1) r_st <= S_RUN;
                end
                S_RUN: begin
                    if (o_pop) begin
                        if (i_item.req_type == REQ_READ) begin
                            r_cv      <= i_item.vertex_index[VW-1:0];
                            r_rd_oob  <= 32'(i_item.vertex_index) >= Vertices;
                            r_rd_ovf  <= i_item.start_of_target;
                            r_rd_pend <= 1'b1;
                        end else if (i_item.req_type == REQ_WEIGHT &&
                                     i_item.last_weight) begin
                            r_vc <= '0;
                            r_st <= S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    r_cv <= r_vc[VW-1:0];
                    r_vc <= r_vc + 1'b1;
                    r_st <= S_COPYW;
                end
                S_COPYW: begin
                    if (32'(r_vc) == Vertices) begin
                        r_m  <= '0;
                        r_st <= S_MSEL;
                    end else
                        r_st <= S_COPY;
                end
                S_MSEL: begin
                    r_e <= '0;
                    r_w <= i_m_wt;
                    if (32'(r_m) == Morphs) r_st <= S_DONE;
                    else if (i_m_wt == '0 || i_m_cnt == '0) r_m <= r_m + 1'b1;
                    else r_st <= S_EREQ;
                end
                S_EREQ: r_st <= S_EWAIT;
                S_EWAIT: r_st <= S_MUL;
                S_MUL: r_st <= S_BRD;
                S_BRD: r_st <= S_ADD;
                S_ADD: begin
                    if (r_e + 1'b1 == i_m_cnt) begin
                        r_m  <= r_m + 1'b1;
                        r_st <= S_MSEL;
                    end else begin
                        r_e  <= r_e + 1'b1;
                        r_st <= S_EREQ;
                    end
                end
                S_DONE: r_st <= S_RUN;
                default: r_st <= S_RUN;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/sparse_morph_target_blend.sv -----
// A read result passes through the command queue, the back end's read stage and the
// result queue; loads, entries, weights and reads are accepted one per cycle while the
// command queue has room, the back end is idle and no blend is pending.
// A last weight holds the input until the blend is done and the weights are cleared.
// After reset a clearing pass over all vertices runs before the first transaction.
// Uses smtb_pkg, smtb_front, smtb_cmdq, smtb_back.
`default_nettype none
module sparse_morph_target_blend (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire smtb_pkg::t_in  i_item,
    output logic                empty,
    input  wire logic           pop,
    output smtb_pkg::t_out      o_result
);
    import smtb_pkg::*;

    logic q_full, q_push, q_empty, q_pop, busy, wt_clr;
    t_in q_in, q_out;
    logic [SW-1:0] e_addr;
    logic [3*CRDW+VW-1:0] e_data;
    logic [MW-1:0] m_sel;
    logic [CW-1:0] m_cnt;
    logic signed [WTW-1:0] m_wt;

    smtb_front u_front (
        .i_clk, .i_rst_n, .i_item, .i_push(push), .o_full(full),
        .i_q_full(q_full), .o_q_push(q_push), .o_q_item(q_in),
        .i_e_addr(e_addr), .o_e_data(e_data), .i_m_sel(m_sel), .o_m_cnt(m_cnt),
        .o_m_wt(m_wt), .i_wt_clr(wt_clr), .i_busy(busy)
    );

    smtb_cmdq u_q (
        .i_clk, .i_rst_n, .i_push(q_push), .i_item(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_item(q_out)
    );

    smtb_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_item(q_out), .o_pop(q_pop),
        .o_busy(busy), .o_wt_clr(wt_clr), .o_e_addr(e_addr), .i_e_data(e_data),
        .o_m_sel(m_sel), .i_m_cnt(m_cnt), .i_m_wt(m_wt),
        .o_empty(empty), .i_pop(pop), .o_res(o_result)
    );
endmodule
`default_nettype wire

// ----- design/smtb_checker.sv -----
// Port-level checker for sparse_morph_target_blend, bound to the top level.
// Uses smtb_pkg.
`default_nettype none
module smtb_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           push,
    input wire logic           full,
    input wire logic           empty,
    input wire logic           pop,
    input wire smtb_pkg::t_out o_result
);
    import smtb_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input taken during clear pass");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_result))
        else $error("waiting result changed");
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.overflow_seen && pop) |=> (empty || o_result.overflow_seen))
        else $error("overflow flag cleared");
endmodule

bind sparse_morph_target_blend smtb_checker u_chk (
    .i_clk, .i_rst_n, .push, .full, .empty, .pop, .o_result
);
`default_nettype wire
